@@ rtl/box_downscale_2x2_unit_defines.svh @@
// Assertion macros shared by the checker files of the 2x2 downscaler.
// Every property is clocked on clk_i and is switched off while rst_ni is low.
`ifndef BOX_DOWNSCALE_2X2_UNIT_DEFINES_SVH
`define BOX_DOWNSCALE_2X2_UNIT_DEFINES_SVH

// General property check.
`define BDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Once cond holds, sig must keep its value on the next edge.
`define BDS_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

@@ rtl/bds_pkg.sv @@
`default_nettype none
package bds_pkg;

  // Fixed widths of the words on the channels.
  localparam int FIELD_BITS     = 16;
  localparam int NUM_FIELDS     = 4;
  localparam int WIDTH_REG_BITS = 13;
  localparam int HEIGHT_BITS    = 14;
  localparam int COMP_REG_BITS  = 3;
  localparam int ROW_BITS       = 13;
  localparam int CFG_ADDR_BITS  = 2;
  localparam int CFG_DATA_BITS  = 14;
  localparam int OUT_WORD_BITS  = NUM_FIELDS * FIELD_BITS;

  // Largest frame height that the row counter covers.
  localparam int MAX_SRC_HEIGHT = 8192;

  // Default build of the block.
  localparam int DEF_MAX_SRC_WIDTH  = 4096;
  localparam int DEF_MAX_COMPONENTS = 4;
  localparam int DEF_SAMPLE_BITS    = 16;

  // Register values after reset.
  localparam logic [WIDTH_REG_BITS-1:0] RST_SRC_WIDTH  = 13'd1920;
  localparam logic [HEIGHT_BITS-1:0]    RST_SRC_HEIGHT = 14'd1080;
  localparam logic [COMP_REG_BITS-1:0]  RST_COMP_COUNT = 3'd3;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_COMP_COUNT = 2'd2
  } cfg_reg_e;

endpackage
`default_nettype wire

@@ rtl/bds_if.sv @@
`default_nettype none
// Source pixel channel.
interface bds_pix_if;
  import bds_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] comp_in_0;
  logic [FIELD_BITS-1:0] comp_in_1;
  logic [FIELD_BITS-1:0] comp_in_2;
  logic [FIELD_BITS-1:0] comp_in_3;
  modport source (output valid, comp_in_0, comp_in_1, comp_in_2, comp_in_3, input ready);
  modport sink   (input valid, comp_in_0, comp_in_1, comp_in_2, comp_in_3, output ready);
endinterface

// Downscaled pixel channel.
interface bds_avg_if;
  import bds_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] avg_out_0;
  logic [FIELD_BITS-1:0] avg_out_1;
  logic [FIELD_BITS-1:0] avg_out_2;
  logic [FIELD_BITS-1:0] avg_out_3;
  logic                  row_end;
  logic                  frame_end;
  modport source (output valid, avg_out_0, avg_out_1, avg_out_2, avg_out_3, row_end,
                  frame_end, input ready);
  modport sink   (input valid, avg_out_0, avg_out_1, avg_out_2, avg_out_3, row_end,
                  frame_end, output ready);
endinterface

// Register write channel.
interface bds_cfg_if;
  import bds_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_ADDR_BITS-1:0] addr;
  logic [CFG_DATA_BITS-1:0] wdata;
  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface
`default_nettype wire

@@ rtl/bds_line_buf.sv @@
`default_nettype none
// Line buffer: one write port, one read port, registered read data.
module bds_line_buf #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 68
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

@@ rtl/box_downscale_2x2_unit.sv @@
`default_nettype none
// 2x2 box downscaler. Accepts one source pixel per cycle while no result waits, needing
// only the single read port and single write port of the line buffer RAM.
// A result is registered, valid in the cycle after the pixel that closes its 2x2 block.
// The output register decouples the sides; input stalls only while a result waits.
// Reset clears the counters, the held samples and the output valid, and loads the
// register defaults; the line buffer is not cleared since every entry is written first.
module box_downscale_2x2_unit #(
  parameter int MAX_SRC_WIDTH  = bds_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_COMPONENTS = bds_pkg::DEF_MAX_COMPONENTS,
  parameter int SAMPLE_BITS    = bds_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bds_pix_if.sink   pix_i,
  bds_avg_if.source avg_o,
  bds_cfg_if.sink   cfg_i
);
  import bds_pkg::*;

  // Column counter covers 0..MAX_SRC_WIDTH-1; EW holds the width itself.
  localparam int CW    = (MAX_SRC_WIDTH > 2) ? $clog2(MAX_SRC_WIDTH) : 1;
  localparam int EW    = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SWB   = (EW > WIDTH_REG_BITS) ? EW : WIDTH_REG_BITS;
  localparam int PAIRS = MAX_SRC_WIDTH / 2;
  localparam int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int PW    = SAMPLE_BITS + 1;
  localparam int DW    = MAX_COMPONENTS * PW;

  // Configuration registers. The port never stalls.
  logic [WIDTH_REG_BITS-1:0] src_width_q;
  logic [HEIGHT_BITS-1:0]    src_height_q;
  logic [COMP_REG_BITS-1:0]  comp_count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= RST_SRC_WIDTH;
      src_height_q <= RST_SRC_HEIGHT;
      comp_count_q <= RST_COMP_COUNT;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        CFG_SRC_WIDTH:  src_width_q  <= cfg_i.wdata[WIDTH_REG_BITS-1:0];
        CFG_SRC_HEIGHT: src_height_q <= cfg_i.wdata[HEIGHT_BITS-1:0];
        CFG_COMP_COUNT: comp_count_q <= cfg_i.wdata[COMP_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame geometry: width clamped to [2, MAX_SRC_WIDTH], height to
  // [2, MAX_SRC_HEIGHT], component count to MAX_COMPONENTS.
  logic [SWB-1:0]           width_ext;
  logic [EW-1:0]            eff_width;
  logic [HEIGHT_BITS-1:0]   eff_height;
  logic [COMP_REG_BITS-1:0] eff_comps;

  always_comb begin
    width_ext = SWB'(src_width_q);
    if (width_ext < SWB'(2)) begin
      eff_width = EW'(2);
    end else if (width_ext > SWB'(MAX_SRC_WIDTH)) begin
      eff_width = EW'(MAX_SRC_WIDTH);
    end else begin
      eff_width = width_ext[EW-1:0];
    end
    if (src_height_q < HEIGHT_BITS'(2)) begin
      eff_height = HEIGHT_BITS'(2);
    end else if (src_height_q > HEIGHT_BITS'(MAX_SRC_HEIGHT)) begin
      eff_height = HEIGHT_BITS'(MAX_SRC_HEIGHT);
    end else begin
      eff_height = src_height_q;
    end
    if (comp_count_q > COMP_REG_BITS'(MAX_COMPONENTS)) begin
      eff_comps = COMP_REG_BITS'(MAX_COMPONENTS);
    end else begin
      eff_comps = comp_count_q;
    end
  end

  // Raster position.
  logic [CW-1:0]       col_q, col_d;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic                accept;

  logic [EW-1:0]          col_inc;
  logic [HEIGHT_BITS-1:0] row_ext, row_inc, height_even;
  logic [CW-1:0]          pair;
  logic [EW-1:0]          pair_ext, out_width;
  logic                   pair_ok, pair_last, row_ok, row_last;

  assign accept      = pix_i.valid && pix_i.ready;
  assign col_inc     = EW'(col_q) + EW'(1);
  assign row_ext     = HEIGHT_BITS'(row_q);
  assign row_inc     = row_ext + HEIGHT_BITS'(1);
  assign height_even = {eff_height[HEIGHT_BITS-1:1], 1'b0};
  assign pair        = col_q >> 1;
  assign pair_ext    = EW'(pair);
  assign out_width   = eff_width >> 1;
  // A pair past the output width is an odd last column and is dropped; the same
  // goes for an odd last row.
  assign pair_ok     = pair_ext < out_width;
  assign pair_last   = (pair_ext + EW'(1)) == out_width;
  assign row_ok      = row_ext < height_even;
  assign row_last    = row_inc == height_even;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_inc >= eff_width) begin
      col_d = '0;
      row_d = (row_inc >= eff_height) ? '0 : row_inc[ROW_BITS-1:0];
    end else begin
      col_d = col_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Incoming samples, cut to the sample width.
  logic [FIELD_BITS-1:0]  pix_comp [NUM_FIELDS];
  logic [SAMPLE_BITS-1:0] samp     [MAX_COMPONENTS];
  logic [SAMPLE_BITS-1:0] held_q   [MAX_COMPONENTS];

  assign pix_comp[0] = pix_i.comp_in_0;
  assign pix_comp[1] = pix_i.comp_in_1;
  assign pix_comp[2] = pix_i.comp_in_2;
  assign pix_comp[3] = pix_i.comp_in_3;

  // An even column only parks its samples until its right-hand partner arrives.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_COMPONENTS; c++) begin
        held_q[c] <= '0;
      end
    end else if (accept && !col_q[0]) begin
      for (int c = 0; c < MAX_COMPONENTS; c++) begin
        held_q[c] <= samp[c];
      end
    end
  end

  // Line buffer traffic. On an even row the right pixel of each pair writes the
  // horizontal sum. On an odd row the left pixel fetches the stored sum, so that
  // the registered read data is waiting when the right pixel arrives. The next
  // fetch comes only with the next left pixel, so the data holds across stalls.
  // A pair is written on one row and read on the next, never in the same cycle.
  logic          wr_en, rd_en, produce;
  logic [AW-1:0] buf_addr;
  logic [DW-1:0] wr_data, rd_data;

  assign buf_addr = pair[AW-1:0];
  assign wr_en    = accept && col_q[0] && !row_q[0] && pair_ok;
  assign rd_en    = accept && !col_q[0] && row_q[0] && pair_ok;
  assign produce  = accept && col_q[0] && row_q[0] && pair_ok && row_ok;

  bds_line_buf #(
    .DEPTH(PAIRS),
    .AW   (AW),
    .DW   (DW)
  ) u_line_buf (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(buf_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(buf_addr),
    .rd_data_o(rd_data)
  );

  // Per-component arithmetic: pair sum on the upper row, four-sample average on
  // the lower row. Components beyond the configured count read as zero.
  logic [FIELD_BITS-1:0] avg_d [NUM_FIELDS];

  for (genvar c = 0; c < NUM_FIELDS; c++) begin : g_lane
    if (c < MAX_COMPONENTS) begin : g_used
      logic [PW:0] quad_sum;
      assign samp[c] = pix_comp[c][SAMPLE_BITS-1:0];
      assign wr_data[c*PW +: PW] = PW'(held_q[c]) + PW'(samp[c]);
      assign quad_sum = (PW+1)'(rd_data[c*PW +: PW]) + (PW+1)'(held_q[c])
                      + (PW+1)'(samp[c]);
      assign avg_d[c] = (COMP_REG_BITS'(c) < eff_comps)
                      ? FIELD_BITS'(quad_sum[PW:2]) : '0;
    end else begin : g_unused
      assign avg_d[c] = '0;
    end
  end

  // Output register. A new pixel is taken whenever the register is empty or is
  // being emptied in the same cycle.
  logic                  avg_valid_q;
  logic [FIELD_BITS-1:0] avg_q [NUM_FIELDS];
  logic                  row_end_q, frame_end_q;

  assign pix_i.ready = !avg_valid_q || avg_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_valid_q <= 1'b0;
    end else if (produce) begin
      avg_valid_q <= 1'b1;
    end else if (avg_o.ready) begin
      avg_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      for (int c = 0; c < NUM_FIELDS; c++) begin
        avg_q[c] <= avg_d[c];
      end
      row_end_q   <= pair_last;
      frame_end_q <= pair_last && row_last;
    end
  end

  assign avg_o.valid     = avg_valid_q;
  assign avg_o.avg_out_0 = avg_q[0];
  assign avg_o.avg_out_1 = avg_q[1];
  assign avg_o.avg_out_2 = avg_q[2];
  assign avg_o.avg_out_3 = avg_q[3];
  assign avg_o.row_end   = row_end_q;
  assign avg_o.frame_end = frame_end_q;

endmodule
`default_nettype wire

@@ rtl/bds_checker.sv @@
`default_nettype none
`include "box_downscale_2x2_unit_defines.svh"
module bds_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           pix_valid,
  input wire logic                           pix_ready,
  input wire logic                           avg_valid,
  input wire logic                           avg_ready,
  input wire logic [bds_pkg::OUT_WORD_BITS+1:0] avg_word,
  input wire logic                           row_end,
  input wire logic                           frame_end,
  input wire logic                           cfg_ready
);
  import bds_pkg::*;

  `BDS_ASSERT_HOLD(a_avg_hold, avg_valid && !avg_ready, {avg_valid, avg_word}, "stalled word changed")
  `BDS_ASSERT(a_frame_row, avg_valid && frame_end |-> row_end, "frame end without row end")
  `BDS_ASSERT(a_in_stall, !pix_ready |-> avg_valid && !avg_ready, "input stalled without cause")
  `BDS_ASSERT(a_no_orphan, $rose(avg_valid) |-> $past(pix_valid && pix_ready), "word without pixel")
  `BDS_ASSERT(a_cfg_ready, cfg_ready, "register port stalled")

endmodule

bind box_downscale_2x2_unit bds_checker u_bds_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .pix_valid(pix_i.valid),
  .pix_ready(pix_i.ready),
  .avg_valid(avg_o.valid),
  .avg_ready(avg_o.ready),
  .avg_word ({avg_o.avg_out_0, avg_o.avg_out_1, avg_o.avg_out_2, avg_o.avg_out_3,
              avg_o.row_end, avg_o.frame_end}),
  .row_end  (avg_o.row_end),
  .frame_end(avg_o.frame_end),
  .cfg_ready(cfg_i.ready)
);
`default_nettype wire
